// ===== src/sfcp_pkg.sv =====
// shared types, constants and tables of the servo frame command parser
package sfcp_pkg;

  localparam int FRAME_CAPACITY = 50;
  localparam int KEPT_CHARS     = 26;
  localparam int POS_W          = $clog2(FRAME_CAPACITY);
  localparam int ADDR_W         = $clog2(KEPT_CHARS);
  localparam int NUM_ANGLES     = 8;
  localparam int K_W            = $clog2(NUM_ANGLES);
  localparam int APB_ADDR_W     = 4;

  localparam logic [7:0] CHAR_OPEN   = 8'h28;
  localparam logic [7:0] CHAR_CLOSE  = 8'h29;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_GROUP1 = 8'h31;
  localparam logic [7:0] CHAR_GROUP2 = 8'h32;

  localparam logic [ADDR_W-1:0] FIRST_DIGIT_ADDR = ADDR_W'(2);

  localparam logic [7:0]  MIN_ANGLE_RESET  = 8'd35;
  localparam logic [7:0]  MAX_ANGLE_RESET  = 8'd175;
  localparam logic [11:0] PULSE_BASE_RESET = 12'd90;

  typedef enum logic [1:0] {
    REG_MIN_ANGLE  = 2'd0,
    REG_MAX_ANGLE  = 2'd1,
    REG_PULSE_BASE = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_index_t;

  localparam logic STATUS_PWM   = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic [7:0]  min_angle;
    logic [7:0]  max_angle;
    logic [11:0] pulse_base;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              clr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wr_data;
    logic [POS_W-1:0]  clr_upto;
  } buf_req_t;

  // pwm controller register address of servo slot k in a group
  function automatic logic [6:0] servo_reg(input logic grp, input logic [K_W-1:0] k);
    logic [4:0] servo;
    servo = 5'd0;
    if (!grp) begin
      case (k)
        3'd0: servo = 5'd8;
        3'd1: servo = 5'd6;
        3'd2: servo = 5'd16;
        3'd3: servo = 5'd7;
        3'd4: servo = 5'd9;
        3'd5: servo = 5'd13;
        3'd6: servo = 5'd11;
        3'd7: servo = 5'd10;
        default: servo = 5'd0;
      endcase
    end else begin
      case (k)
        3'd0: servo = 5'd1;
        3'd1: servo = 5'd2;
        3'd2: servo = 5'd5;
        3'd3: servo = 5'd3;
        3'd4: servo = 5'd4;
        3'd5: servo = 5'd15;
        3'd6: servo = 5'd14;
        3'd7: servo = 5'd12;
        default: servo = 5'd0;
      endcase
    end
    return {servo, 2'b10};
  endfunction

endpackage

// ===== src/sfcp_if.sv =====
// stream interfaces for received bytes and pwm write results
interface sfcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfcp_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [6:0]  reg_address;
  logic [11:0] pwm_off;
  logic        last;

  modport source (output valid, output status, output reg_address, output pwm_off,
                  output last, input ready);
  modport sink (input valid, input status, input reg_address, input pwm_off,
                input last, output ready);
endinterface

// ===== src/sfcp_buffer.sv =====
// frame character memory with per-entry valid bits
module sfcp_buffer (
  input  logic                clk,
  input  logic                rst,
  input  sfcp_pkg::buf_req_t  req,
  output logic [7:0]          rd_data
);

  logic [7:0]                      mem [sfcp_pkg::KEPT_CHARS];
  logic [sfcp_pkg::KEPT_CHARS-1:0] valid;
  logic [7:0]                      rd_q;
  logic                            rd_ok;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.addr] <= 1'b1;
      end else if (req.clr_en) begin
        for (int i = 0; i < sfcp_pkg::KEPT_CHARS; i++) begin
          if (sfcp_pkg::POS_W'(i) <= req.clr_upto) begin
            valid[i] <= 1'b0;
          end
        end
      end
      if (req.rd_en) begin
        rd_ok <= valid[req.addr];
      end
    end
  end

  // never written or cleared entries read as zero
  assign rd_data = rd_ok ? rd_q : 8'd0;

endmodule

// ===== src/sfcp_ctrl.sv =====
// byte handling, frame parse sequencer and result register
module sfcp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  sfcp_pkg::cfg_t     cfg,
  sfcp_byte_if.sink          rx,
  sfcp_result_if.source      res,
  output sfcp_pkg::buf_req_t buf_req,
  input  logic [7:0]         buf_rd_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_GROUP = 6'b000010,
    S_DIGIT = 6'b000100,
    S_EMIT  = 6'b001000,
    S_ERR   = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  state_t                          state, state_next;
  logic [sfcp_pkg::POS_W-1:0]      pos, pos_next;
  logic                            grp, grp_next;
  logic [1:0]                      sub, sub_next;
  logic [sfcp_pkg::K_W-1:0]        k, k_next;
  logic [7:0]                      acc, acc_next;
  logic [sfcp_pkg::ADDR_W-1:0]     last_addr, last_addr_next;
  logic [7:0]                      angle [sfcp_pkg::NUM_ANGLES];
  logic                            angle_we;

  logic                            out_valid, out_valid_next;
  logic                            out_load;
  logic                            out_status, out_status_next;
  logic [6:0]                      out_reg, out_reg_next;
  logic [11:0]                     out_off, out_off_next;
  logic                            out_last, out_last_next;

  logic                            accept;
  logic                            out_free;
  logic [7:0]                      ch_eff;
  logic [7:0]                      digit;
  logic [7:0]                      acc_base;
  logic [7:0]                      acc_step;
  logic [sfcp_pkg::NUM_ANGLES-1:0] in_rng;
  logic                            more;

  assign rx.ready = (state == S_IDLE);
  assign accept   = rx.valid && rx.ready;
  assign out_free = !out_valid || res.ready;

  // the entry at the write position reads as the frame terminator
  assign ch_eff   = ({{(sfcp_pkg::POS_W-sfcp_pkg::ADDR_W){1'b0}}, last_addr} == pos) ?
                    8'd0 : buf_rd_data;
  assign digit    = ch_eff - sfcp_pkg::CHAR_ZERO;
  assign acc_base = (sub == 2'd0) ? 8'd0 : acc;
  assign acc_step = (acc_base << 3) + (acc_base << 1) + digit;

  always_comb begin
    for (int j = 0; j < sfcp_pkg::NUM_ANGLES; j++) begin
      in_rng[j] = (angle[j] >= cfg.min_angle) && (angle[j] <= cfg.max_angle);
    end
    more = 1'b0;
    for (int j = 0; j < sfcp_pkg::NUM_ANGLES; j++) begin
      if (j > int'(k) && in_rng[j]) begin
        more = 1'b1;
      end
    end
  end

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    grp_next        = grp;
    sub_next        = sub;
    k_next          = k;
    acc_next        = acc;
    last_addr_next  = last_addr;
    angle_we        = 1'b0;
    out_load        = 1'b0;
    out_status_next = out_status;
    out_reg_next    = out_reg;
    out_off_next    = out_off;
    out_last_next   = out_last;
    buf_req         = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (rx.rx_byte == sfcp_pkg::CHAR_OPEN) begin
            pos_next = '0;
          end else if (rx.rx_byte == sfcp_pkg::CHAR_CLOSE) begin
            buf_req.rd_en  = 1'b1;
            buf_req.addr   = '0;
            last_addr_next = '0;
            state_next     = S_GROUP;
          end else if (pos < sfcp_pkg::POS_W'(sfcp_pkg::FRAME_CAPACITY - 1)) begin
            if (pos < sfcp_pkg::POS_W'(sfcp_pkg::KEPT_CHARS)) begin
              buf_req.wr_en   = 1'b1;
              buf_req.addr    = pos[sfcp_pkg::ADDR_W-1:0];
              buf_req.wr_data = rx.rx_byte;
            end
            pos_next = pos + 1'b1;
          end
        end
      end
      S_GROUP: begin
        if (ch_eff == sfcp_pkg::CHAR_GROUP1 || ch_eff == sfcp_pkg::CHAR_GROUP2) begin
          grp_next       = (ch_eff == sfcp_pkg::CHAR_GROUP2);
          buf_req.rd_en  = 1'b1;
          buf_req.addr   = sfcp_pkg::FIRST_DIGIT_ADDR;
          last_addr_next = sfcp_pkg::FIRST_DIGIT_ADDR;
          sub_next       = 2'd0;
          k_next         = '0;
          state_next     = S_DIGIT;
        end else begin
          state_next = S_ERR;
        end
      end
      S_DIGIT: begin
        if (sub == 2'd2) begin
          angle_we = 1'b1;
          sub_next = 2'd0;
          if (k == sfcp_pkg::K_W'(sfcp_pkg::NUM_ANGLES - 1)) begin
            k_next     = '0;
            state_next = S_EMIT;
          end else begin
            k_next = k + 1'b1;
          end
        end else begin
          acc_next = acc_step;
          sub_next = sub + 2'd1;
        end
        if (!(sub == 2'd2 && k == sfcp_pkg::K_W'(sfcp_pkg::NUM_ANGLES - 1))) begin
          buf_req.rd_en  = 1'b1;
          buf_req.addr   = last_addr + 1'b1;
          last_addr_next = last_addr + 1'b1;
        end
      end
      S_EMIT: begin
        if (!in_rng[k] || out_free) begin
          if (in_rng[k]) begin
            out_load        = 1'b1;
            out_status_next = sfcp_pkg::STATUS_PWM;
            out_reg_next    = sfcp_pkg::servo_reg(grp, k);
            out_off_next    = {3'b000, angle[k], 1'b0} + cfg.pulse_base;
            out_last_next   = !more;
          end
          if (k == sfcp_pkg::K_W'(sfcp_pkg::NUM_ANGLES - 1)) begin
            state_next = S_CLEAR;
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = sfcp_pkg::STATUS_ERROR;
          out_reg_next    = 7'd0;
          out_off_next    = 12'd0;
          out_last_next   = 1'b1;
          state_next      = S_CLEAR;
        end
      end
      S_CLEAR: begin
        buf_req.clr_en   = 1'b1;
        buf_req.clr_upto = pos;
        pos_next         = '0;
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (res.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    grp        <= grp_next;
    sub        <= sub_next;
    k          <= k_next;
    acc        <= acc_next;
    last_addr  <= last_addr_next;
    out_status <= out_status_next;
    out_reg    <= out_reg_next;
    out_off    <= out_off_next;
    out_last   <= out_last_next;
    if (angle_we) begin
      angle[k] <= acc_step;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.reg_address = out_reg;
  assign res.pwm_off     = out_off;
  assign res.last        = out_last;

endmodule

// ===== src/servo_frame_command_parser.sv =====
// top level: configuration registers, frame buffer and parse controller
//
//  channel  dir  handshake            payload
//  rx       in   valid/ready          rx_byte
//  cmd      out  valid/ready          status, reg_address, pwm_off, last
//  apb      in   psel/penable/pready  paddr, pwdata, prdata
//
// an ordinary byte or an opening bracket is taken in the idle state, which it does not leave
// a closing bracket starts a parse, held by output stalls: the accept, one group
// read, 24 digit reads through the single buffer port, 8 emit steps, one clear
// an unknown group runs the group check, error result and clear, plus output stalls
// buffer valid bits and position clear at once on reset; no clearing pass
// a waiting result holds the emit step until the output register is free
module servo_frame_command_parser (
  input  logic                            clk,
  input  logic                            rst,
  sfcp_byte_if.sink                       rx,
  sfcp_result_if.source                   cmd,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfcp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  sfcp_pkg::cfg_t       cfg;
  sfcp_pkg::buf_req_t   buf_req;
  logic [7:0]           buf_rd_data;
  sfcp_pkg::reg_index_t reg_idx;
  logic                 wr_req;

  assign pready  = 1'b1;
  assign reg_idx = sfcp_pkg::reg_index_t'(paddr[3:2]);
  assign wr_req  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_angle  <= sfcp_pkg::MIN_ANGLE_RESET;
      cfg.max_angle  <= sfcp_pkg::MAX_ANGLE_RESET;
      cfg.pulse_base <= sfcp_pkg::PULSE_BASE_RESET;
    end else if (wr_req) begin
      case (reg_idx)
        sfcp_pkg::REG_MIN_ANGLE:  cfg.min_angle  <= pwdata[7:0];
        sfcp_pkg::REG_MAX_ANGLE:  cfg.max_angle  <= pwdata[7:0];
        sfcp_pkg::REG_PULSE_BASE: cfg.pulse_base <= pwdata[11:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfcp_pkg::REG_MIN_ANGLE:  prdata = {24'd0, cfg.min_angle};
      sfcp_pkg::REG_MAX_ANGLE:  prdata = {24'd0, cfg.max_angle};
      sfcp_pkg::REG_PULSE_BASE: prdata = {20'd0, cfg.pulse_base};
      default:                  prdata = 32'd0;
    endcase
  end

  sfcp_buffer u_buffer (
    .clk     (clk),
    .rst     (rst),
    .req     (buf_req),
    .rd_data (buf_rd_data)
  );

  sfcp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .rx          (rx),
    .res         (cmd),
    .buf_req     (buf_req),
    .buf_rd_data (buf_rd_data)
  );

  a_error_fields : assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.status == sfcp_pkg::STATUS_ERROR) |->
      (cmd.reg_address == 7'd0 && cmd.pwm_off == 12'd0 && cmd.last))
    else $error("error result with nonzero fields or not last");

  a_close_busy : assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready && rx.rx_byte == sfcp_pkg::CHAR_CLOSE) |=> !rx.ready)
    else $error("closing bracket did not start a parse");

  a_result_in_parse : assert property (@(posedge clk) disable iff (rst)
    $rose(cmd.valid) |-> !rx.ready)
    else $error("result appeared outside a parse");

  a_buf_exclusive : assert property (@(posedge clk) disable iff (rst)
    !(buf_req.wr_en && (buf_req.rd_en || buf_req.clr_en)))
    else $error("buffer write overlaps a read or clear");

endmodule

// ===== tb/tb.sv =====
// testbench for servo_frame_command_parser: framed byte stimulus, checked pwm writes
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic        status;
    logic [6:0]  reg_address;
    logic [11:0] pwm_off;
    logic        last;
  } pwm_write_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    pwm_write_t result;
  } dir_row_t;

  localparam pwm_write_t FRAME_ERROR = {sfcp_pkg::STATUS_ERROR, 7'd0, 12'd0, 1'b1};
  localparam pwm_write_t NO_RESULT   = '0;
  localparam int DIR_ROWS = 25;

  // servo number per slot, group one in entries 0..7, group two in 8..15
  localparam logic [15:0][4:0] SERVO_SLOTS = {
    5'd12, 5'd14, 5'd15, 5'd4, 5'd3, 5'd5, 5'd2, 5'd1,
    5'd10, 5'd11, 5'd13, 5'd9, 5'd7, 5'd16, 5'd6, 5'd8
  };

  localparam logic [4:0][7:0]  PH_LO    = {8'd180, 8'd255, 8'd100, 8'd35, 8'd0};
  localparam logic [4:0][7:0]  PH_HI    = {8'd0, 8'd255, 8'd255, 8'd175, 8'd255};
  localparam logic [4:0][11:0] PH_BASE  = {12'd1234, 12'd4000, 12'd4095, 12'd90, 12'd0};
  localparam logic [4:0][6:0]  PH_FEED  = {7'd0, 7'd21, 7'd0, 7'd64, 7'd0};
  localparam logic [4:0][6:0]  PH_STALL = {7'd0, 7'd21, 7'd64, 7'd0, 7'd0};
  localparam logic [4:0][7:0]  PH_BYTES = {8'd25, 8'd50, 8'd50, 8'd50, 8'd50};

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [sfcp_pkg::APB_ADDR_W-1:0] paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  sfcp_byte_if   rx_ch();
  sfcp_result_if cmd_ch();

  servo_frame_command_parser uut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .cmd     (cmd_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [7:0]  frame_mem [sfcp_pkg::KEPT_CHARS];
  logic [5:0]  fill_pos;
  logic [7:0]  lim_lo;
  logic [7:0]  lim_hi;
  logic [11:0] pulse_off;
  pwm_write_t  burst [8];
  pwm_write_t  pending_writes [$];

  int feed_idle_pct;
  int drain_stall_pct;
  int fail_count;
  int bytes_sent;
  int writes_seen;
  int errors_seen;

  dir_row_t dir_rows [DIR_ROWS] = '{
    {sfcp_pkg::CHAR_CLOSE, 1'b1, FRAME_ERROR},
    {sfcp_pkg::CHAR_OPEN, 1'b0, NO_RESULT},
    {8'h39, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_CLOSE, 1'b1, FRAME_ERROR},
    {8'hFF, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_CLOSE, 1'b1, FRAME_ERROR},
    {8'h00, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_CLOSE, 1'b1, FRAME_ERROR},
    {sfcp_pkg::CHAR_OPEN, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_GROUP1, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_CLOSE, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_GROUP2, 1'b0, NO_RESULT},
    {8'h2C, 1'b0, NO_RESULT},
    {8'h31, 1'b0, NO_RESULT},
    {8'h37, 1'b0, NO_RESULT},
    {8'h35, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_CLOSE, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_GROUP1, 1'b0, NO_RESULT},
    {8'h2C, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_ZERO, 1'b0, NO_RESULT},
    {8'h33, 1'b0, NO_RESULT},
    {8'h34, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_CLOSE, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_OPEN, 1'b0, NO_RESULT},
    {sfcp_pkg::CHAR_CLOSE, 1'b1, FRAME_ERROR}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cmd_ch.ready <= ($urandom_range(0, 99) >= drain_stall_pct);
  end

  function automatic int frame_step(input logic [7:0] ch);
    int n;
    int k;
    int j;
    int p;
    int acc;
    int grp;
    logic [7:0] ang;
    n = 0;
    if (ch == sfcp_pkg::CHAR_OPEN) begin
      fill_pos = '0;
    end else if (ch == sfcp_pkg::CHAR_CLOSE) begin
      if (fill_pos < sfcp_pkg::KEPT_CHARS) begin
        frame_mem[fill_pos] = 8'd0;
      end
      if (frame_mem[0] == sfcp_pkg::CHAR_GROUP1 || frame_mem[0] == sfcp_pkg::CHAR_GROUP2) begin
        grp = (frame_mem[0] == sfcp_pkg::CHAR_GROUP2) ? 8 : 0;
        for (k = 0; k < sfcp_pkg::NUM_ANGLES; k++) begin
          p = 2 + 3 * k;
          acc = (int'(frame_mem[p]) - 48) * 100 + (int'(frame_mem[p + 1]) - 48) * 10
                + int'(frame_mem[p + 2]) - 48;
          ang = acc[7:0];
          if (ang >= lim_lo && ang <= lim_hi) begin
            acc = 2 * int'(ang) + int'(pulse_off);
            burst[n].status = sfcp_pkg::STATUS_PWM;
            burst[n].reg_address = {SERVO_SLOTS[grp + k], 2'b10};
            burst[n].pwm_off = acc[11:0];
            burst[n].last = 1'b0;
            n++;
          end
        end
        if (n > 0) begin
          burst[n - 1].last = 1'b1;
        end
      end else begin
        burst[0] = FRAME_ERROR;
        n = 1;
      end
      for (j = 0; j <= fill_pos && j < sfcp_pkg::KEPT_CHARS; j++) begin
        frame_mem[j] = 8'd0;
      end
      fill_pos = '0;
    end else if (fill_pos < sfcp_pkg::FRAME_CAPACITY - 1) begin
      if (fill_pos < sfcp_pkg::KEPT_CHARS) begin
        frame_mem[fill_pos] = ch;
      end
      fill_pos = fill_pos + 6'd1;
    end
    return n;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    pwm_write_t want;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      if (pending_writes.size() == 0) begin
        $error("result with nothing pending: status %0d reg_address %0d pwm_off %0d",
               cmd_ch.status, cmd_ch.reg_address, cmd_ch.pwm_off);
        fail_count++;
      end else begin
        want = pending_writes.pop_front();
        check_field("status", want.status, cmd_ch.status);
        check_field("reg_address", want.reg_address, cmd_ch.reg_address);
        check_field("pwm_off", want.pwm_off, cmd_ch.pwm_off);
        check_field("last", want.last, cmd_ch.last);
        if (want.status == sfcp_pkg::STATUS_ERROR) begin
          errors_seen++;
        end else begin
          writes_seen++;
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic typed, input pwm_write_t fixed);
    int n;
    int i;
    while ($urandom_range(0, 99) < feed_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= ch;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
    n = frame_step(ch);
    if (typed) begin
      pending_writes.push_back(fixed);
    end else begin
      for (i = 0; i < n; i++) begin
        pending_writes.push_back(burst[i]);
      end
    end
  endtask

  task automatic send_noise();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    if (ch == sfcp_pkg::CHAR_OPEN || ch == sfcp_pkg::CHAR_CLOSE) begin
      ch = ch ^ 8'h80;
    end
    send_char(ch, 1'b0, NO_RESULT);
  endtask

  task automatic send_frame(input logic stretch);
    int n_ang;
    int k;
    int val;
    logic [7:0] digits [3];
    int d;
    if ($urandom_range(0, 9) != 0) begin
      send_char(sfcp_pkg::CHAR_OPEN, 1'b0, NO_RESULT);
    end
    case ($urandom_range(0, 9))
      0: send_char(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
      1, 2, 3, 4, 5: send_char(sfcp_pkg::CHAR_GROUP1, 1'b0, NO_RESULT);
      default: send_char(sfcp_pkg::CHAR_GROUP2, 1'b0, NO_RESULT);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      send_noise();
    end else begin
      send_char(8'h2C, 1'b0, NO_RESULT);
    end
    n_ang = $urandom_range(0, 1) ? sfcp_pkg::NUM_ANGLES
                                 : $urandom_range(0, sfcp_pkg::NUM_ANGLES);
    for (k = 0; k < n_ang; k++) begin
      case ($urandom_range(0, 5))
        0: val = $urandom_range(0, 999);
        1: val = lim_lo;
        2: val = lim_hi;
        3: val = int'(lim_lo) + 255;
        4: val = int'(lim_hi) + 1;
        default: val = $urandom_range(0, 255);
      endcase
      digits[0] = sfcp_pkg::CHAR_ZERO + 8'(val / 100);
      digits[1] = sfcp_pkg::CHAR_ZERO + 8'((val / 10) % 10);
      digits[2] = sfcp_pkg::CHAR_ZERO + 8'(val % 10);
      for (d = 0; d < 3; d++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_noise();
        end else begin
          send_char(digits[d], 1'b0, NO_RESULT);
        end
      end
    end
    if (stretch) begin
      repeat ($urandom_range(24, 34)) send_noise();
    end
    if ($urandom_range(0, 9) != 0) begin
      send_char(sfcp_pkg::CHAR_CLOSE, 1'b0, NO_RESULT);
    end
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input sfcp_pkg::reg_index_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      sfcp_pkg::REG_MIN_ANGLE: lim_lo = val[7:0];
      sfcp_pkg::REG_MAX_ANGLE: lim_hi = val[7:0];
      sfcp_pkg::REG_PULSE_BASE: pulse_off = val[11:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int r;
    int ph;
    int start;
    logic first;
    rst <= 1'b1;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= 8'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    feed_idle_pct = 0;
    drain_stall_pct = 0;
    fail_count = 0;
    bytes_sent = 0;
    writes_seen = 0;
    errors_seen = 0;
    for (r = 0; r < sfcp_pkg::KEPT_CHARS; r++) begin
      frame_mem[r] = 8'd0;
    end
    fill_pos = '0;
    lim_lo = sfcp_pkg::MIN_ANGLE_RESET;
    lim_hi = sfcp_pkg::MAX_ANGLE_RESET;
    pulse_off = sfcp_pkg::PULSE_BASE_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIR_ROWS; r++) begin
      send_char(dir_rows[r].ch, dir_rows[r].typed, dir_rows[r].result);
    end

    for (ph = 0; ph < 5; ph++) begin
      settle();
      write_reg(sfcp_pkg::REG_MIN_ANGLE, {24'd0, PH_LO[ph]});
      write_reg(sfcp_pkg::REG_MAX_ANGLE, {24'd0, PH_HI[ph]});
      write_reg(sfcp_pkg::REG_PULSE_BASE, {20'd0, PH_BASE[ph]});
      feed_idle_pct = PH_FEED[ph];
      drain_stall_pct = PH_STALL[ph];
      start = bytes_sent;
      first = 1'b1;
      while (bytes_sent - start < PH_BYTES[ph]) begin
        send_frame((first && ph % 2 == 1) || $urandom_range(0, 99) < 4);
        repeat ($urandom_range(0, 2)) send_noise();
        first = 1'b0;
      end
    end
    settle();

    $display("sent %0d bytes: directed frames, then five limit and pacing settings", bytes_sent);
    $display("checked %0d pwm writes and %0d syntax errors", writes_seen, errors_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sfcp_pkg.sv
src/sfcp_if.sv
src/sfcp_buffer.sv
src/sfcp_ctrl.sv
src/servo_frame_command_parser.sv
tb/tb.sv
